// File: rtl/wmw_pkg.sv
// ----------------------------------------------------------------------------
// wmw_pkg
// Shared types, constants and helpers for the word multiset window matcher.
// ----------------------------------------------------------------------------
package wmw_pkg;

    localparam int MAX_WORD_LEN = 8;
    localparam int MAX_WORDS    = 16;
    localparam int ENT_W        = $clog2(MAX_WORDS);
    localparam int PH_W         = $clog2(MAX_WORD_LEN);
    localparam int CNT_W        = $clog2(MAX_WORDS + 1);
    localparam int ADDR_W       = PH_W + ENT_W;
    localparam int DEPTH        = MAX_WORD_LEN * MAX_WORDS;

    localparam logic [1:0] REQ_CLEAR   = 2'd0;
    localparam logic [1:0] REQ_ADD     = 2'd1;
    localparam logic [1:0] REQ_TEXT    = 2'd2;
    localparam logic [1:0] REQ_RESTART = 2'd3;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_MATCH = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] dict_entry;
        logic [7:0]  text_byte;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] match_start;
    } t_out_beat;

    typedef enum logic [3:0] {
        K_CLEAR   = 4'b0001,
        K_ADD     = 4'b0010,
        K_TEXT    = 4'b0100,
        K_RESTART = 4'b1000
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] dict_entry;
        logic [7:0]  text_byte;
    } t_job;

    function automatic logic [3:0] eff_len(input logic [3:0] len);
        logic [3:0] r;
        r = len;
        if (len == 4'd0) begin
            r = 4'd1;
        end else if (len > 4'(MAX_WORD_LEN)) begin
            r = 4'(MAX_WORD_LEN);
        end
        return r;
    endfunction

    function automatic logic [63:0] word_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < len) begin
                m[i*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// File: rtl/wmw_front.sv
// ----------------------------------------------------------------------------
// wmw_front
// Accepts input beats, decodes the request type and queues them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module wmw_front import wmw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_beat i_in_data,
    output logic     o_job_valid,
    input  logic     i_job_pop,
    output t_job     o_job
);

    t_job       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_job       w_job;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_job.dict_entry = i_in_data.dict_entry;
        w_job.text_byte  = i_in_data.text_byte;
        case (i_in_data.req_type)
            REQ_CLEAR: w_job.kind = K_CLEAR;
            REQ_ADD:   w_job.kind = K_ADD;
            REQ_TEXT:  w_job.kind = K_TEXT;
            default:   w_job.kind = K_RESTART;
        endcase
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = i_job_pop && o_job_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

// File: rtl/wmw_back.sv
// ----------------------------------------------------------------------------
// wmw_back
// Executes queued jobs: dictionary updates and the per-phase sliding window
// over text words, with one result beat per job.
// ----------------------------------------------------------------------------
module wmw_back import wmw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    input  logic       i_job_valid,
    output logic       o_job_pop,
    input  t_job       i_job,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_beat  o_out_data
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_ADD  = 10'b0000000010,
        ST_FIND = 10'b0000000100,
        ST_SEEN = 10'b0000001000,
        ST_LOOP = 10'b0000010000,
        ST_POP1 = 10'b0000100000,
        ST_POP2 = 10'b0001000000,
        ST_PUSH = 10'b0010000000,
        ST_EMIT = 10'b0100000000,
        ST_SPARE = 10'b1000000000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [3:0]        r_len;
    logic [63:0]       r_words [MAX_WORDS];
    logic [CNT_W-1:0]  r_needed [MAX_WORDS];
    logic [CNT_W-1:0]  r_used;
    logic [CNT_W-1:0]  r_total;
    logic [63:0]       r_recent;
    logic [31:0]       r_pos;
    logic [PH_W-1:0]   r_phase;
    logic [3:0]        r_fill;
    logic [CNT_W-1:0]  r_wsize [MAX_WORD_LEN];
    logic [ENT_W-1:0]  r_whead [MAX_WORD_LEN];
    logic [DEPTH-1:0]  r_seen_vld;
    logic [CNT_W-1:0]  r_seen_mem [DEPTH];
    logic [ENT_W-1:0]  r_ring_mem [DEPTH];
    logic [CNT_W-1:0]  r_seen_q;
    logic              r_seen_vq;
    logic [ENT_W-1:0]  r_ring_q;
    logic [MAX_WORDS-1:0] r_hit;
    logic [63:0]       r_w;
    logic [PH_W-1:0]   r_ph;
    logic [ENT_W-1:0]  r_found;
    logic [ENT_W-1:0]  r_f;
    logic [CNT_W-1:0]  r_sf;
    logic [31:0]       r_wstart;
    t_out_beat         r_res;
    logic              r_out_valid;
    t_out_beat         r_out;

    logic [3:0]        w_l;
    logic [63:0]       w_mask;
    logic [63:0]       w_recent;
    logic [PH_W-1:0]   w_phase;
    logic [3:0]        w_fill;
    logic [63:0]       w_key;
    logic [MAX_WORDS-1:0] w_hit;
    logic [ENT_W-1:0]  w_enc;
    logic              w_any;
    logic [ADDR_W-1:0] w_seen_ra;
    logic [ADDR_W-1:0] w_ring_ra;
    logic              w_seen_we;
    logic [ADDR_W-1:0] w_seen_wa;
    logic [CNT_W-1:0]  w_seen_wd;
    logic              w_ring_we;
    logic [ADDR_W-1:0] w_ring_wa;
    logic [CNT_W-1:0]  w_sv;
    logic              w_out_free;
    logic              w_need_pop;
    logic [8:0]        w_span;

    assign w_l        = eff_len(r_len);
    assign w_mask     = word_mask(w_l);
    assign w_recent   = {r_recent[55:0], i_job.text_byte};
    assign w_phase    = ({1'b0, r_phase} + 4'd1 >= w_l) ? '0 : r_phase + 1'b1;
    assign w_fill     = (r_fill < w_l) ? r_fill + 4'd1 : r_fill;
    assign w_key      = ((i_job.kind == K_TEXT) ? w_recent : i_job.dict_entry) & w_mask;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_job_pop  = (r_state == ST_IDLE) && i_job_valid;
    assign w_sv       = r_seen_vq ? r_seen_q : '0;
    assign w_need_pop = (({1'b0, r_sf} + 6'd1) > {1'b0, r_needed[r_found]})
                        && (r_wsize[r_ph] != '0);
    assign w_span     = 9'(r_wsize[r_ph]) * 9'(w_l);

    always_comb begin
        for (int e = 0; e < MAX_WORDS; e++) begin
            w_hit[e] = (CNT_W'(e) < r_used) && (r_words[e] == w_key)
                       && ((i_job.kind != K_TEXT) || (r_needed[e] != '0));
        end
    end

    always_comb begin
        w_enc = '0;
        w_any = 1'b0;
        for (int e = MAX_WORDS - 1; e >= 0; e--) begin
            if (r_hit[e]) begin
                w_enc = ENT_W'(e);
                w_any = 1'b1;
            end
        end
    end

    always_comb begin
        w_seen_ra = {r_ph, w_enc};
        w_ring_ra = {r_ph, r_whead[r_ph]};
        if (r_state == ST_POP1) begin
            w_seen_ra = {r_ph, r_ring_q};
        end
        w_seen_we = 1'b0;
        w_seen_wa = {r_ph, r_found};
        w_seen_wd = r_sf + 1'b1;
        w_ring_we = 1'b0;
        w_ring_wa = {r_ph, r_whead[r_ph] + r_wsize[r_ph][ENT_W-1:0]};
        if (r_state == ST_POP2) begin
            w_seen_we = (w_sv != '0);
            w_seen_wa = {r_ph, r_f};
            w_seen_wd = w_sv - 1'b1;
        end else if (r_state == ST_PUSH && r_wsize[r_ph] < CNT_W'(MAX_WORDS)) begin
            w_seen_we = 1'b1;
            w_ring_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seen_q  <= r_seen_mem[w_seen_ra];
        r_seen_vq <= r_seen_vld[w_seen_ra];
        r_ring_q  <= r_ring_mem[w_ring_ra];
        if (w_seen_we) begin
            r_seen_mem[w_seen_wa] <= w_seen_wd;
        end
        if (w_ring_we) begin
            r_ring_mem[w_ring_wa] <= r_found;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    case (i_job.kind)
                        K_ADD:   n_state = ST_ADD;
                        K_TEXT:  n_state = (w_fill < w_l) ? ST_EMIT : ST_FIND;
                        default: n_state = ST_EMIT;
                    endcase
                end
            end
            ST_ADD:  n_state = ST_EMIT;
            ST_FIND: n_state = w_any ? ST_SEEN : ST_EMIT;
            ST_SEEN: n_state = ST_LOOP;
            ST_LOOP: n_state = w_need_pop ? ST_POP1 : ST_PUSH;
            ST_POP1: n_state = ST_POP2;
            ST_POP2: n_state = ST_LOOP;
            ST_PUSH: n_state = ST_EMIT;
            ST_EMIT: n_state = w_out_free ? ST_IDLE : ST_EMIT;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= 4'd1;
            r_used      <= '0;
            r_total     <= '0;
            r_recent    <= '0;
            r_pos       <= '0;
            r_phase     <= '0;
            r_fill      <= '0;
            r_ph        <= '0;
            r_seen_vld  <= '0;
            r_out_valid <= 1'b0;
            for (int e = 0; e < MAX_WORDS; e++) begin
                r_needed[e] <= '0;
            end
            for (int p = 0; p < MAX_WORD_LEN; p++) begin
                r_wsize[p] <= '0;
                r_whead[p] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_out_ready && r_state != ST_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_hit <= w_hit;
                    r_w   <= w_key;
                    r_res <= '{status: STS_OK, match_start: '0};
                    if (i_job_valid) begin
                        if (i_job.kind == K_TEXT) begin
                            r_recent <= w_recent;
                            r_pos    <= r_pos + 32'd1;
                            r_phase  <= w_phase;
                            r_fill   <= w_fill;
                            r_ph     <= w_phase;
                            r_wstart <= r_pos - 32'(w_l - 4'd1);
                        end else if (i_job.kind == K_CLEAR || i_job.kind == K_RESTART) begin
                            r_recent   <= '0;
                            r_pos      <= '0;
                            r_phase    <= '0;
                            r_fill     <= '0;
                            r_seen_vld <= '0;
                            for (int p = 0; p < MAX_WORD_LEN; p++) begin
                                r_wsize[p] <= '0;
                                r_whead[p] <= '0;
                            end
                            if (i_job.kind == K_CLEAR) begin
                                r_used  <= '0;
                                r_total <= '0;
                                for (int e = 0; e < MAX_WORDS; e++) begin
                                    r_needed[e] <= '0;
                                end
                            end
                        end
                    end
                end
                ST_ADD: begin
                    if (r_total >= CNT_W'(MAX_WORDS)) begin
                        r_res.status <= STS_FULL;
                    end else if (w_any) begin
                        r_needed[w_enc] <= r_needed[w_enc] + 1'b1;
                        r_total         <= r_total + 1'b1;
                    end else if (r_used >= CNT_W'(MAX_WORDS)) begin
                        r_res.status <= STS_FULL;
                    end else begin
                        r_words[r_used[ENT_W-1:0]]  <= r_w;
                        r_needed[r_used[ENT_W-1:0]] <= CNT_W'(1);
                        r_used  <= r_used + 1'b1;
                        r_total <= r_total + 1'b1;
                    end
                end
                ST_FIND: begin
                    r_found <= w_enc;
                    if (!w_any) begin
                        r_wsize[r_ph] <= '0;
                        r_whead[r_ph] <= '0;
                        for (int e = 0; e < MAX_WORDS; e++) begin
                            r_seen_vld[{r_ph, ENT_W'(e)}] <= 1'b0;
                        end
                    end
                end
                ST_SEEN: begin
                    r_sf <= w_sv;
                end
                ST_POP1: begin
                    r_f <= r_ring_q;
                end
                ST_POP2: begin
                    if (w_sv != '0) begin
                        r_seen_vld[{r_ph, r_f}] <= 1'b1;
                        if (r_f == r_found) begin
                            r_sf <= w_sv - 1'b1;
                        end
                    end
                    r_whead[r_ph] <= r_whead[r_ph] + 1'b1;
                    r_wsize[r_ph] <= r_wsize[r_ph] - 1'b1;
                end
                ST_PUSH: begin
                    if (r_wsize[r_ph] < CNT_W'(MAX_WORDS)) begin
                        r_seen_vld[{r_ph, r_found}] <= 1'b1;
                        r_wsize[r_ph] <= r_wsize[r_ph] + 1'b1;
                        if (r_total != '0 && r_wsize[r_ph] + 1'b1 == r_total) begin
                            r_res.status      <= STS_MATCH;
                            r_res.match_start <= r_wstart - 32'(w_span);
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= r_res;
                    end
                end
                default: begin
                end
            endcase
            if (i_cfg_we) begin
                r_len      <= i_cfg_wdata;
                r_recent   <= '0;
                r_pos      <= '0;
                r_phase    <= '0;
                r_fill     <= '0;
                r_seen_vld <= '0;
                for (int p = 0; p < MAX_WORD_LEN; p++) begin
                    r_wsize[p] <= '0;
                    r_whead[p] <= '0;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(MAX_WORDS))
        else $error("Dictionary multiplicity total exceeds its capacity.");

    a_used_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= r_total)
        else $error("More distinct entries than words in the dictionary.");

    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wsize[r_ph] <= CNT_W'(MAX_WORDS))
        else $error("Window of the current phase is larger than the ring.");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_state != ST_IDLE))
        else $error("A job was taken but the back end stayed idle.");

endmodule

// File: rtl/word_multiset_window_match_top.sv
// ----------------------------------------------------------------------------
// word_multiset_window_match_top
// Dictionary of equal-length words with multiplicities, matched against a
// byte stream by one sliding word window per phase.
// ----------------------------------------------------------------------------
// Every input beat gives exactly one result beat. A clear, restart or
// partial-word text beat goes from idle straight to the emit state, a
// dictionary add through the add state, a word missing from the dictionary
// through the find state, and a found word through the find, seen and loop
// states, two pop states per word dropped from the left of its window, and
// the push state; each drop reads the window ring and then the count memory.
// A two-entry queue sits in front of the engine, a registered result stage
// behind it, and a result that is not taken holds the engine. Writing the
// word length restarts the text and must only happen while the block is idle.
module word_multiset_window_match_top import wmw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_beat   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_beat  o_out_data,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata
);

    logic job_valid;
    logic job_pop;
    t_job job;

    wmw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job_valid (job_valid),
        .i_job_pop   (job_pop),
        .o_job       (job)
    );

    wmw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_job_valid (job_valid),
        .o_job_pop   (job_pop),
        .i_job       (job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
